// ===== rtl/stks_pkg.sv =====
// ---------------------------------------------------------------------------
// stks_pkg
// Shared types and constants for the slot table key store: table geometry,
// command codes, controller states and the control/status bundles.
// ---------------------------------------------------------------------------
package stks_pkg;

  // Table geometry, fixed by the field widths of the block
  localparam int unsigned SLOTS  = 32;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned KEY_W  = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted beat
    logic search;  // register the slot search
    logic update;  // commit table change, read entry, work out last
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic last;    // the pending result is the final one of its command
  } stat_t;

endpackage

// ===== rtl/stks_in_if.sv =====
// ---------------------------------------------------------------------------
// stks_in_if
// Command channel of the slot table key store: valid/ready plus one command.
// ---------------------------------------------------------------------------
interface stks_in_if
  import stks_pkg::*;
#(
  parameter int unsigned DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  logic signed [31:0]   entry_key;
  logic [DATA_BITS-1:0] entry_data;
  logic [CNT_W-1:0]     list_limit;

  modport source (output valid, command, entry_key, entry_data, list_limit,
                  input ready);
  modport sink   (input valid, command, entry_key, entry_data, list_limit,
                  output ready);
endinterface

// ===== rtl/stks_out_if.sv =====
// ---------------------------------------------------------------------------
// stks_out_if
// Result channel of the slot table key store: valid/ready plus one result.
// ---------------------------------------------------------------------------
interface stks_out_if
  import stks_pkg::*;
#(
  parameter int unsigned DATA_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [SLOT_W-1:0]    slot;
  logic signed [31:0]   out_key;
  logic [DATA_BITS-1:0] out_data;
  logic [CNT_W-1:0]     stored_count;
  logic                 full_res;
  logic [CNT_W-1:0]     list_position;
  logic                 last;

  modport source (output valid, ok, slot, out_key, out_data, stored_count,
                  full_res, list_position, last,
                  input ready);
  modport sink   (input valid, ok, slot, out_key, out_data, stored_count,
                  full_res, list_position, last,
                  output ready);
endinterface

// ===== rtl/stks_ctrl.sv =====
// ---------------------------------------------------------------------------
// stks_ctrl
// Sequencer: accept a command, search, update/read, present the result beat;
// loops back to search while a list has more entries to emit.
// ---------------------------------------------------------------------------
module stks_ctrl
  import stks_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_ready_i) state_d = stat_i.last ? ST_IDLE : ST_SEARCH;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    ctrl_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ST_SEARCH: ctrl_o.search = 1'b1;
      ST_UPDATE: ctrl_o.update = 1'b1;
      ST_RESULT: out_valid_o   = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/stks_dp.sv =====
// ---------------------------------------------------------------------------
// stks_dp
// Datapath: slot table storage, capacity register, parallel key compare and
// lowest-slot priority encode, and the result registers.
// ---------------------------------------------------------------------------
module stks_dp
  import stks_pkg::*;
#(
  parameter int unsigned DATA_BITS = 32
)(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i,
  input  logic [1:0]            command_i,
  input  logic signed [31:0]    entry_key_i,
  input  logic [DATA_BITS-1:0]  entry_data_i,
  input  logic [CNT_W-1:0]      list_limit_i,
  output logic                  ok_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic signed [31:0]    out_key_o,
  output logic [DATA_BITS-1:0]  out_data_o,
  output logic [CNT_W-1:0]      stored_count_o,
  output logic                  full_res_o,
  output logic [CNT_W-1:0]      list_position_o,
  output logic                  last_o
);

  // Storage
  logic [SLOTS-1:0]     valid_q;
  logic [KEY_W-1:0]     key_mem   [SLOTS];
  logic [DATA_BITS-1:0] data_mem  [SLOTS];
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     cap_q;

  // Captured command
  cmd_e                 cmd_q;
  logic [KEY_W-1:0]     key_q;
  logic [DATA_BITS-1:0] data_q;
  logic [CNT_W-1:0]     limit_q;

  // Search and result state
  logic [CNT_W-1:0]     scan_q;
  logic [CNT_W-1:0]     emitted_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 hit_q;
  logic                 last_q;
  logic [KEY_W-1:0]     rd_key_q;
  logic [DATA_BITS-1:0] rd_data_q;

  logic [SLOTS-1:0]     in_range;
  logic [SLOTS-1:0]     cand;
  logic [SLOTS-1:0]     more_vec;
  logic [SLOT_W-1:0]    pick;
  logic                 more;
  logic [CNT_W-1:0]     emitted_nxt;
  logic [CNT_W-1:0]     limit_sat;

  // Capacity register: out-of-range writes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(SLOTS);
    end else if (cfg_we_i && cfg_wdata_i != '0 && cfg_wdata_i <= CNT_W'(SLOTS)) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Candidate slots for the current command
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_range[i] = (CNT_W'(i) < cap_q) && (CNT_W'(i) >= scan_q);
      more_vec[i] = valid_q[i] && (CNT_W'(i) < cap_q) &&
                    (CNT_W'(i) > {1'b0, slot_q});
    end
    case (cmd_q)
      CMD_INSERT: cand = ~valid_q & in_range & {SLOTS{count_q < cap_q}};
      CMD_REMOVE, CMD_LOOKUP: begin
        for (int i = 0; i < SLOTS; i++) begin
          cand[i] = valid_q[i] && in_range[i] && (key_mem[i] == key_q);
        end
      end
      default: cand = valid_q & in_range & {SLOTS{emitted_q < limit_q}};
    endcase
  end

  // Lowest candidate wins
  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) pick = SLOT_W'(i);
    end
  end

  assign more        = |more_vec;
  assign emitted_nxt = emitted_q + CNT_W'(1);
  assign limit_sat   = (list_limit_i > cap_q) ? cap_q : list_limit_i;

  // Command capture and search registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_e'(command_i);
      key_q   <= entry_key_i;
      data_q  <= entry_data_i;
      limit_q <= limit_sat;
    end
    if (ctrl_i.search) begin
      slot_q <= pick;
    end
    if (ctrl_i.update) begin
      rd_key_q  <= key_mem[slot_q];
      rd_data_q <= data_mem[slot_q];
    end
  end

  // Table contents: written on a successful insert
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update && hit_q && cmd_q == CMD_INSERT) begin
      key_mem[slot_q]  <= key_q;
      data_mem[slot_q] <= data_q;
    end
  end

  // Control state: valid bits, count, list progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      emitted_q <= '0;
      hit_q     <= 1'b0;
      last_q    <= 1'b1;
    end else begin
      if (ctrl_i.load) begin
        scan_q    <= '0;
        emitted_q <= '0;
      end
      if (ctrl_i.search) begin
        hit_q <= |cand;
      end
      if (ctrl_i.update) begin
        // only a list hit can leave more beats to come
        if (hit_q && cmd_q == CMD_LIST) begin
          last_q <= !(more && (emitted_nxt < limit_q));
        end else begin
          last_q <= 1'b1;
        end
        if (hit_q) begin
          case (cmd_q)
            CMD_INSERT: begin
              valid_q[slot_q] <= 1'b1;
              count_q         <= count_q + CNT_W'(1);
            end
            CMD_REMOVE: begin
              valid_q[slot_q] <= 1'b0;
              if (count_q != '0) count_q <= count_q - CNT_W'(1);
            end
            CMD_LIST: begin
              scan_q    <= {1'b0, slot_q} + CNT_W'(1);
              emitted_q <= emitted_nxt;
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign stat_o.last = last_q;

  // Result beat
  assign ok_o            = hit_q;
  assign slot_o          = hit_q ? slot_q : '0;
  assign out_key_o       = (hit_q && cmd_q != CMD_INSERT) ? rd_key_q : '0;
  assign out_data_o      = (hit_q && cmd_q != CMD_INSERT) ? rd_data_q : '0;
  assign stored_count_o  = count_q;
  assign full_res_o      = (count_q >= cap_q);
  assign list_position_o = (hit_q && cmd_q == CMD_LIST) ? emitted_q : '0;
  assign last_o          = last_q;

endmodule

// ===== rtl/slot_table_key_store_unit.sv =====
// ---------------------------------------------------------------------------
// slot_table_key_store_unit
// A 32-slot keyed table with insert, remove, lookup and list commands. One
// command is handled at a time: each result beat passes the search,
// update/read and present states plus any wait for the result to be taken.
// Insert, remove and lookup emit one beat; a list emits one beat per entry
// it returns (one beat when nothing qualifies). The sequencer walks search,
// table update with registered entry read, and result stages. Key match
// and free-slot search run over all slots in parallel and the lowest slot
// wins. Capacity is written through cfg_we_i/cfg_wdata_i while idle;
// the user is bound to this, the block itself does not enforce it. Writes
// of 0 or above 32 are ignored. Key/data contents need no clearing after
// reset: only the valid bits are reset.
// ---------------------------------------------------------------------------
module slot_table_key_store_unit
  import stks_pkg::*;
#(
  parameter int unsigned DATA_BITS = 32
)(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  stks_in_if.sink          req_i,
  stks_out_if.source       rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer
  stks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Table and result datapath
  stks_dp #(
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (req_i.command),
    .entry_key_i     (req_i.entry_key),
    .entry_data_i    (req_i.entry_data),
    .list_limit_i    (req_i.list_limit),
    .ok_o            (rsp_o.ok),
    .slot_o          (rsp_o.slot),
    .out_key_o       (rsp_o.out_key),
    .out_data_o      (rsp_o.out_data),
    .stored_count_o  (rsp_o.stored_count),
    .full_res_o      (rsp_o.full_res),
    .list_position_o (rsp_o.list_position),
    .last_o          (rsp_o.last)
  );

`ifndef ASSERT_OFF
  // Never take a command while a result beat is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("command accepted while result pending");

  // A failed or empty result always ends its command
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> rsp_o.last)
    else $error("failed result not marked last");

  // List positions only appear on successful beats
  a_pos_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.list_position != '0) |-> rsp_o.ok)
    else $error("list position on failed beat");

  // Entry count never exceeds the table size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.stored_count <= CNT_W'(SLOTS)))
    else $error("stored count beyond table size");
`endif

endmodule

// ===== bench/slot_table_key_store_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// slot_table_key_store_unit_tb
// Self-checking bench for the slot table key store. A short directed table
// covers the empty table, the key and data extremes, duplicate keys, the
// list limit and capacity changes, including writes that must be ignored.
// Random commands follow, drawn mostly from a small key pool so that removes
// and lookups hit. The table model, or a hand-written row, predicts every
// result beat, and each beat taken from the block is checked field by field
// against it. Both channels idle at random, at rates set per phase; the last of three phases never idles.
// ---------------------------------------------------------------------------
module slot_table_key_store_unit_tb;
  import stks_pkg::*;

  localparam int unsigned DW          = 32;
  localparam int unsigned SETTLE      = 4;     // idle cycles before a capacity write
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat before giving up
  localparam int unsigned SEG_ITEMS   = 50;

  typedef struct {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  key;
    logic [DW-1:0]     data;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic [CNT_W-1:0]  pos;
    logic              last;
  } tbl_result_t;

  typedef enum bit {ROW_OP, ROW_CAP} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    cmd_e             op;
    logic [KEY_W-1:0] key;
    logic [DW-1:0]    data;
    logic [CNT_W-1:0] limit;
    bit               typed;
    tbl_result_t      want;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  stks_in_if  #(.DATA_BITS(DW)) req_if ();
  stks_out_if #(.DATA_BITS(DW)) rsp_if ();

  slot_table_key_store_unit #(.DATA_BITS(DW)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // Table model
  bit               slot_used [SLOTS];
  logic [KEY_W-1:0] slot_key  [SLOTS];
  logic [DW-1:0]    slot_data [SLOTS];
  int unsigned      used_count;
  int unsigned      cap_model;

  tbl_result_t op_results [$];    // beats of the command just accepted
  tbl_result_t pending    [$];    // beats still owed by the block
  stim_row_t   dir_rows   [$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned mismatches;
  int unsigned stall_cycles;

  // Capacity for each random segment; 0, 33 and 63 must leave it unchanged
  int unsigned seg_caps [9] = '{32, 1, 0, 6, 63, 20, 33, 2, 32};

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result beat as seen after the command has changed the table
  function automatic tbl_result_t make_result(logic ok, int unsigned slot,
      logic [KEY_W-1:0] key, logic [DW-1:0] data, int unsigned pos, logic last);
    tbl_result_t r;
    r.ok    = ok;
    r.slot  = slot[SLOT_W-1:0];
    r.key   = key;
    r.data  = data;
    r.count = used_count[CNT_W-1:0];
    r.full  = (used_count >= cap_model);
    r.pos   = pos[CNT_W-1:0];
    r.last  = last;
    return r;
  endfunction

  // Apply one command to the table model, leaving its beats in op_results
  function automatic void apply_table_op(cmd_e op, logic [KEY_W-1:0] key,
      logic [DW-1:0] data, logic [CNT_W-1:0] limit);
    int          hit;
    int unsigned lim;
    int unsigned n;
    hit = -1;
    n   = 0;
    op_results.delete();
    case (op)
      CMD_INSERT: begin
        if (used_count < cap_model)
          for (int i = 0; i < int'(cap_model); i++)
            if (hit < 0 && !slot_used[i]) hit = i;
        if (hit >= 0) begin
          slot_used[hit] = 1'b1;
          slot_key[hit]  = key;
          slot_data[hit] = data;
          used_count++;
          op_results.push_back(make_result(1'b1, hit, '0, '0, 0, 1'b1));
        end else begin
          op_results.push_back(make_result(1'b0, 0, '0, '0, 0, 1'b1));
        end
      end
      CMD_REMOVE, CMD_LOOKUP: begin
        for (int i = 0; i < int'(cap_model); i++)
          if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
        if (hit < 0) begin
          op_results.push_back(make_result(1'b0, 0, '0, '0, 0, 1'b1));
        end else begin
          if (op == CMD_REMOVE) begin
            slot_used[hit] = 1'b0;
            if (used_count > 0) used_count--;
          end
          op_results.push_back(make_result(1'b1, hit, slot_key[hit], slot_data[hit], 0, 1'b1));
        end
      end
      default: begin
        // list: limit saturates at capacity, valid slots in order
        lim = (limit > cap_model) ? cap_model : limit;
        for (int i = 0; i < int'(cap_model) && n < lim; i++)
          if (slot_used[i]) begin
            n++;
            op_results.push_back(make_result(1'b1, i, slot_key[i], slot_data[i], n, 1'b0));
          end
        if (n == 0) op_results.push_back(make_result(1'b0, 0, '0, '0, 0, 1'b1));
        else op_results[n-1].last = 1'b1;
      end
    endcase
  endfunction

  // Directed table builders
  function automatic void add_op(cmd_e op, logic [KEY_W-1:0] key, logic [DW-1:0] data,
      logic [CNT_W-1:0] limit);
    stim_row_t r;
    r = '{kind: ROW_OP, op: op, key: key, data: data, limit: limit, typed: 1'b0,
          want: '{default: '0}};
    dir_rows.push_back(r);
  endfunction

  // Row whose single beat is written out by hand (position 0, last set)
  function automatic void add_chk(cmd_e op, logic [KEY_W-1:0] key, logic [DW-1:0] data,
      logic [CNT_W-1:0] limit, logic ok, int unsigned slot, logic [KEY_W-1:0] rkey,
      logic [DW-1:0] rdata, int unsigned cnt, logic full);
    stim_row_t r;
    r = '{kind: ROW_OP, op: op, key: key, data: data, limit: limit, typed: 1'b1,
          want: '{default: '0}};
    r.want.ok    = ok;
    r.want.slot  = slot[SLOT_W-1:0];
    r.want.key   = rkey;
    r.want.data  = rdata;
    r.want.count = cnt[CNT_W-1:0];
    r.want.full  = full;
    r.want.last  = 1'b1;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cap(logic [CNT_W-1:0] value);
    stim_row_t r;
    r = '{kind: ROW_CAP, op: CMD_INSERT, key: '0, data: '0, limit: value, typed: 1'b0,
          want: '{default: '0}};
    dir_rows.push_back(r);
  endfunction

  // Key mostly from a small pool so that removes and lookups find entries
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 20) return $urandom;
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic cmd_e pick_op(int unsigned ins_pct);
    int unsigned r;
    int unsigned rest;
    r    = $urandom_range(99);
    rest = 100 - ins_pct;
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + rest * 4 / 10) return CMD_REMOVE;
    if (r < ins_pct + rest * 7 / 10) return CMD_LOOKUP;
    return CMD_LIST;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Drive one command beat; the model is updated at the accepting edge
  task automatic send_op(cmd_e op, logic [KEY_W-1:0] key, logic [DW-1:0] data,
      logic [CNT_W-1:0] limit, bit typed, tbl_result_t want);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.command    <= op;
    req_if.entry_key  <= key;
    req_if.entry_data <= data;
    req_if.list_limit <= limit;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    apply_table_op(op, key, data, limit);
    if (typed) pending.push_back(want);
    else foreach (op_results[i]) pending.push_back(op_results[i]);
  endtask

  // Hold the command channel until every owed beat has come back
  task automatic drain_pending();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] value);
    drain_pending();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (value >= 1 && value <= SLOTS) cap_model = value;
  endtask

  // Result side: random back-pressure
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    tbl_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected beat, slot", 32'(rsp_if.slot), '0);
      end else begin
        want = pending.pop_front();
        check_field("ok",            32'(rsp_if.ok),            32'(want.ok));
        check_field("slot",          32'(rsp_if.slot),          32'(want.slot));
        check_field("out_key",       rsp_if.out_key,            want.key);
        check_field("out_data",      rsp_if.out_data,           want.data);
        check_field("stored_count",  32'(rsp_if.stored_count),  32'(want.count));
        check_field("full_res",      32'(rsp_if.full_res),      32'(want.full));
        check_field("list_position", 32'(rsp_if.list_position), 32'(want.pos));
        check_field("last",          32'(rsp_if.last),          32'(want.last));
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni) stall_cycles = 0;
    else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    tbl_result_t none;
    int unsigned ins_pct;
    none              = '{default: '0};
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.command    = CMD_INSERT;
    req_if.entry_key  = '0;
    req_if.entry_data = '0;
    req_if.list_limit = '0;
    rsp_if.ready      = 1'b0;
    mismatches        = 0;
    src_idle_pct      = 10;
    snk_idle_pct      = 46;
    cap_model         = SLOTS;
    used_count        = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, starting from the empty table at full capacity
    add_chk(CMD_LOOKUP, 32'h0, 32'h0, 6'd0, 0, 0, 32'h0, 32'h0, 0, 0);
    add_chk(CMD_LIST, 32'h0, 32'h0, 6'd32, 0, 0, 32'h0, 32'h0, 0, 0);
    add_chk(CMD_REMOVE, 32'h5, 32'h0, 6'd0, 0, 0, 32'h0, 32'h0, 0, 0);
    add_chk(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 6'd0, 1, 0, 32'h0, 32'h0, 1, 0);
    add_chk(CMD_INSERT, 32'h7FFF_FFFF, 32'h0, 6'd63, 1, 1, 32'h0, 32'h0, 2, 0);
    add_chk(CMD_INSERT, 32'hFFFF_FFFF, 32'h5555_5555, 6'd0, 1, 2, 32'h0, 32'h0, 3, 0);
    // duplicate key lands in its own slot
    add_chk(CMD_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 6'd0, 1, 3, 32'h0, 32'h0, 4, 0);
    add_chk(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0, 6'd0, 1, 1, 32'h7FFF_FFFF, 32'h0, 4, 0);
    add_chk(CMD_LIST, 32'h0, 32'h0, 6'd0, 0, 0, 32'h0, 32'h0, 4, 0);
    add_op(CMD_LIST, 32'h0, 32'h0, 6'd63);
    add_op(CMD_LIST, 32'h0, 32'h0, 6'd2);
    add_chk(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0, 6'd0, 1, 1, 32'h7FFF_FFFF, 32'h0, 3, 0);
    add_chk(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0, 6'd0, 1, 3, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 3, 0);
    add_chk(CMD_INSERT, 32'h1, 32'h1, 6'd0, 1, 1, 32'h0, 32'h0, 4, 0);
    add_chk(CMD_REMOVE, 32'h1234_5678, 32'h0, 6'd0, 0, 0, 32'h0, 32'h0, 4, 0);
    // shrink to a full table
    add_cap(6'd4);
    add_chk(CMD_INSERT, 32'h9, 32'h9, 6'd0, 0, 0, 32'h0, 32'h0, 4, 1);
    add_op(CMD_LIST, 32'h0, 32'h0, 6'd32);
    add_cap(6'd0);
    add_cap(6'd63);
    add_chk(CMD_LOOKUP, 32'h1, 32'h0, 6'd0, 1, 1, 32'h1, 32'h1, 4, 1);
    // capacity of one slot: the rest stay counted but out of reach
    add_cap(6'd1);
    add_chk(CMD_LOOKUP, 32'h1, 32'h0, 6'd0, 0, 0, 32'h0, 32'h0, 4, 1);
    add_op(CMD_LIST, 32'h0, 32'h0, 6'd32);
    add_chk(CMD_REMOVE, 32'h8000_0000, 32'h0, 6'd0, 1, 0, 32'h8000_0000, 32'hFFFF_FFFF, 3, 1);
    add_chk(CMD_INSERT, 32'h2, 32'h2, 6'd0, 0, 0, 32'h0, 32'h0, 3, 1);
    add_cap(6'd32);
    add_chk(CMD_INSERT, 32'h2, 32'h2, 6'd0, 1, 0, 32'h0, 32'h0, 4, 0);
    add_op(CMD_LIST, 32'h0, 32'h0, 6'd5);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) write_capacity(dir_rows[i].limit);
      else send_op(dir_rows[i].op, dir_rows[i].key, dir_rows[i].data, dir_rows[i].limit,
                    dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part: three phases of idling rates, three capacity segments each
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 46 : 0;
      snk_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 10 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        write_capacity(CNT_W'(seg_caps[ph * 3 + seg]));
        ins_pct = $urandom_range(25, 65);
        for (int k = 0; k < int'(SEG_ITEMS); k++) begin
          if ($urandom_range(99) < 3) drain_pending();
          send_op(pick_op(ins_pct), pick_key(), $urandom, CNT_W'($urandom_range(0, 63)),
                  1'b0, none);
        end
      end
    end

    drain_pending();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
